@@ design/memory_word_pattern_scanner_core_assert.svh @@
// Assertion macros shared by the memory word pattern scanner modules.
`ifndef MEMORY_WORD_PATTERN_SCANNER_CORE_ASSERT_SVH
`define MEMORY_WORD_PATTERN_SCANNER_CORE_ASSERT_SVH
`ifndef SYNTH
// Checks that a condition holds at every clock edge outside reset.
`define MWPS_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("scanner assertion failed");
// Checks that a consequent holds in the same cycle as its antecedent.
`define MWPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner assertion failed");
// Checks that a consequent holds in the cycle after its antecedent.
`define MWPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner assertion failed");
`else
`define MWPS_ASSERT_ALWAYS(label, clk, rst, expr)
`define MWPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MWPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/mwps_pkg.sv @@
// Types and constants shared by the memory word pattern scanner modules.
package mwps_pkg;

  localparam int MAX_NEEDLE_WORDS    = 8;
  localparam int MAX_EXCLUDED_RANGES = 16;
  localparam int WIN_DEPTH           = (MAX_NEEDLE_WORDS > 4) ? MAX_NEEDLE_WORDS : 4;
  localparam int NLEN_W              = 4;
  localparam int FILL_W              = $clog2(WIN_DEPTH + 1);
  localparam int USED_W              = $clog2(MAX_EXCLUDED_RANGES + 1);
  localparam int RIDX_W              = (MAX_EXCLUDED_RANGES > 1) ?
                                       $clog2(MAX_EXCLUDED_RANGES) : 1;
  localparam int SPAN_W              = $clog2(4 * MAX_NEEDLE_WORDS + 1);
  localparam int PTR_W               = 47;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QPTR_W              = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

  // Input operation codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RANGE = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  // Hit kinds.
  localparam logic KIND_INLINE = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_NEEDLE_LENGTH = 3'd0;
  localparam logic [2:0] REG_NEEDLE_A      = 3'd1;
  localparam logic [2:0] REG_NEEDLE_B      = 3'd2;
  localparam logic [2:0] REG_NEEDLE_C      = 3'd3;
  localparam logic [2:0] REG_NEEDLE_D      = 3'd4;

  // Commands passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_HIT   = 2'd2
  } cmd_t;

  typedef logic [MAX_NEEDLE_WORDS-1:0][31:0] needle_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] data_word;
    logic [31:0] range_start;
    logic [31:0] range_length;
  } item_t;

  typedef struct packed {
    logic              hit_kind;
    logic [31:0]       hit_offset;
    logic [NLEN_W-1:0] element_count;
    logic [PTR_W-1:0]  array_pointer;
    logic [31:0]       array_capacity;
    logic              inside_excluded;
    logic              last_of_run;
  } result_t;

  // One queue entry: a hit candidate, a range load or a table clear.
  // A range load carries its start in offset and its length in capacity.
  typedef struct packed {
    cmd_t              cmd;
    logic              kind;
    logic [31:0]       offset;
    logic [NLEN_W-1:0] count;
    logic [PTR_W-1:0]  pointer;
    logic [31:0]       capacity;
    logic [SPAN_W-1:0] span;
    logic              last;
  } entry_t;

endpackage

@@ design/mwps_front.sv @@
// Front end: takes input items, keeps the word window and finds hit candidates.
module mwps_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  mwps_pkg::item_t            item,
  input  logic [mwps_pkg::NLEN_W-1:0] needle_length,
  input  mwps_pkg::needle_t          needle,
  output logic                       q_push,
  output mwps_pkg::entry_t           q_data,
  input  logic                       q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_EVAL = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t                      state;
  front_state_t                      state_next;
  logic [31:0]                       win [mwps_pkg::WIN_DEPTH];
  logic [mwps_pkg::FILL_W-1:0]       fill;
  logic [31:0]                       seen;
  logic [1:0]                        cur_op;
  logic [31:0]                       cur_idx;
  logic [31:0]                       cur_start;
  logic [31:0]                       cur_len;
  mwps_pkg::entry_t                  pend_a;
  mwps_pkg::entry_t                  pend_b;
  logic                              pend_a_v;
  logic                              pend_b_v;
  mwps_pkg::entry_t                  eval_a;
  mwps_pkg::entry_t                  eval_b;
  logic                              eval_a_v;
  logic                              eval_b_v;
  logic                              accept;
  logic [mwps_pkg::MAX_NEEDLE_WORDS:0] len_match;
  logic                              inline_hit;
  logic                              hdr_hit;
  logic [63:0]                       hdr_ptr;
  logic [31:0]                       inline_word;
  logic [31:0]                       hdr_word;
  mwps_pkg::entry_t                  inline_entry;
  mwps_pkg::entry_t                  hdr_entry;

  assign full   = (state != F_IDLE);
  assign accept = push && !full;

  // Control state and the scan position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      fill     <= '0;
      seen     <= '0;
      pend_a_v <= 1'b0;
      pend_b_v <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (item.operation == mwps_pkg::OP_START) begin
          fill <= '0;
          seen <= '0;
        end else if (item.operation == mwps_pkg::OP_DATA) begin
          seen <= seen + 32'd1;
          if (fill < mwps_pkg::FILL_W'(mwps_pkg::WIN_DEPTH)) begin
            fill <= fill + 1'b1;
          end
        end
      end
      if (state == F_EVAL) begin
        pend_a_v <= eval_a_v;
        pend_b_v <= eval_b_v;
      end else if (q_push) begin
        if (pend_a_v) begin
          pend_a_v <= 1'b0;
        end else begin
          pend_b_v <= 1'b0;
        end
      end
    end
  end

  // Window shift and the registered copy of the accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op    <= item.operation;
      cur_idx   <= seen;
      cur_start <= item.range_start;
      cur_len   <= item.range_length;
      if (item.operation == mwps_pkg::OP_DATA) begin
        for (int k = 0; k < mwps_pkg::WIN_DEPTH - 1; k++) begin
          win[k] <= win[k+1];
        end
        win[mwps_pkg::WIN_DEPTH-1] <= item.data_word;
      end
    end
    if (state == F_EVAL) begin
      pend_a <= eval_a;
      pend_b <= eval_b;
    end
  end

  // Inline match for every possible needle length, aligned to the newest word.
  always_comb begin
    logic ok;
    len_match[0] = 1'b0;
    for (int l = 1; l <= mwps_pkg::MAX_NEEDLE_WORDS; l++) begin
      ok = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win[mwps_pkg::WIN_DEPTH-l+i] != needle[i]) begin
          ok = 1'b0;
        end
      end
      len_match[l] = ok;
    end
  end

  assign inline_hit = (needle_length != '0) &&
                      (needle_length <= mwps_pkg::NLEN_W'(mwps_pkg::MAX_NEEDLE_WORDS)) &&
                      (fill >= needle_length) && len_match[needle_length];

  // Array header check over the four newest words.
  assign hdr_ptr = {win[mwps_pkg::WIN_DEPTH-3], win[mwps_pkg::WIN_DEPTH-4]};
  assign hdr_hit = (needle_length != '0) && cur_idx[0] &&
                   (fill >= mwps_pkg::FILL_W'(4)) &&
                   (win[mwps_pkg::WIN_DEPTH-2] == {{(32-mwps_pkg::NLEN_W){1'b0}}, needle_length}) &&
                   (win[mwps_pkg::WIN_DEPTH-1] >= win[mwps_pkg::WIN_DEPTH-2]) &&
                   (hdr_ptr[2:0] == 3'd0) && (hdr_ptr[63:16] != '0) &&
                   (hdr_ptr[63:mwps_pkg::PTR_W] == '0);

  assign inline_word = cur_idx + 32'd1 - {{(32-mwps_pkg::NLEN_W){1'b0}}, needle_length};
  assign hdr_word    = cur_idx - 32'd3;

  // Build the hit candidate entries.
  always_comb begin
    inline_entry          = '0;
    inline_entry.cmd      = mwps_pkg::CMD_HIT;
    inline_entry.kind     = mwps_pkg::KIND_INLINE;
    inline_entry.offset   = {inline_word[29:0], 2'b00};
    inline_entry.count    = needle_length;
    inline_entry.span     = {needle_length[mwps_pkg::SPAN_W-3:0], 2'b00};
    inline_entry.last     = !hdr_hit;
    hdr_entry             = '0;
    hdr_entry.cmd         = mwps_pkg::CMD_HIT;
    hdr_entry.kind        = mwps_pkg::KIND_HEADER;
    hdr_entry.offset      = {hdr_word[29:0], 2'b00};
    hdr_entry.count       = needle_length;
    hdr_entry.pointer     = hdr_ptr[mwps_pkg::PTR_W-1:0];
    hdr_entry.capacity    = win[mwps_pkg::WIN_DEPTH-1];
    hdr_entry.span        = mwps_pkg::SPAN_W'(16);
    hdr_entry.last        = 1'b1;
  end

  // Classify the accepted item into at most two queue entries.
  always_comb begin
    eval_a   = '0;
    eval_b   = hdr_entry;
    eval_a_v = 1'b0;
    eval_b_v = 1'b0;
    case (cur_op)
      mwps_pkg::OP_START: begin
        eval_a.cmd = mwps_pkg::CMD_CLEAR;
        eval_a_v   = 1'b1;
      end
      mwps_pkg::OP_RANGE: begin
        eval_a.cmd      = mwps_pkg::CMD_LOAD;
        eval_a.offset   = cur_start;
        eval_a.capacity = cur_len;
        eval_a_v        = (cur_len != 32'd0);
      end
      mwps_pkg::OP_DATA: begin
        if (inline_hit) begin
          eval_a   = inline_entry;
          eval_a_v = 1'b1;
          eval_b_v = hdr_hit;
        end else begin
          eval_a   = hdr_entry;
          eval_a_v = hdr_hit;
        end
      end
      default: begin
        eval_a_v = 1'b0;
      end
    endcase
  end

  // Sequencer: accept, classify, then hand entries to the queue one at a time.
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = F_EVAL;
        end
      end
      F_EVAL: begin
        state_next = (eval_a_v || eval_b_v) ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (q_push && !(pend_a_v && pend_b_v)) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = pend_a_v ? pend_a : pend_b;

endmodule

@@ design/mwps_queue.sv @@
// Short queue of commands between the front end and the back end.
`include "memory_word_pattern_scanner_core_assert.svh"
module mwps_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  mwps_pkg::entry_t wr_data,
  output logic             wr_full,
  input  logic             rd_en,
  output mwps_pkg::entry_t rd_data,
  output logic             rd_empty
);

  mwps_pkg::entry_t            slots [mwps_pkg::QUEUE_DEPTH];
  logic [mwps_pkg::QPTR_W-1:0] wr_ptr;
  logic [mwps_pkg::QPTR_W-1:0] rd_ptr;
  logic [mwps_pkg::QCNT_W-1:0] count;

  assign wr_full  = (count == mwps_pkg::QCNT_W'(mwps_pkg::QUEUE_DEPTH));
  assign rd_empty = (count == '0);
  assign rd_data  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == mwps_pkg::QPTR_W'(mwps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == mwps_pkg::QPTR_W'(mwps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `MWPS_ASSERT_IMPL(a_queue_no_overflow, clk, rst, wr_en, !wr_full)
  `MWPS_ASSERT_IMPL(a_queue_no_underflow, clk, rst, rd_en, !rd_empty)

endmodule

@@ design/mwps_back.sv @@
// Back end: keeps the excluded range table, checks hits against it, holds the result.
`include "memory_word_pattern_scanner_core_assert.svh"
module mwps_back (
  input  logic             clk,
  input  logic             rst,
  output logic             q_pop,
  input  mwps_pkg::entry_t q_data,
  input  logic             q_empty,
  output logic             empty,
  input  logic             pop,
  output mwps_pkg::result_t result
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_WAIT = 3'b100
  } back_state_t;

  back_state_t                  state;
  logic [31:0]                  starts  [mwps_pkg::MAX_EXCLUDED_RANGES];
  logic [31:0]                  lengths [mwps_pkg::MAX_EXCLUDED_RANGES];
  logic [mwps_pkg::USED_W-1:0]  used;
  logic [mwps_pkg::USED_W-1:0]  scan;
  mwps_pkg::entry_t             cur;
  logic                         excl;
  logic                         out_valid;
  logic                         out_load;
  logic [32:0]                  span_lo;
  logic [32:0]                  span_hi;
  logic [32:0]                  rng_lo;
  logic [32:0]                  rng_hi;
  logic                         overlap;
  logic                         table_wr;

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign table_wr = q_pop && (q_data.cmd == mwps_pkg::CMD_LOAD) &&
                    (used < mwps_pkg::USED_W'(mwps_pkg::MAX_EXCLUDED_RANGES));
  assign out_load = (state == B_WAIT) && (!out_valid || pop);
  assign empty    = !out_valid;

  // Half-open overlap of the hit span with the range under the scan index.
  assign span_lo = {1'b0, cur.offset};
  assign span_hi = {1'b0, cur.offset} + {{(33-mwps_pkg::SPAN_W){1'b0}}, cur.span};
  assign rng_lo  = {1'b0, starts[scan[mwps_pkg::RIDX_W-1:0]]};
  assign rng_hi  = rng_lo + {1'b0, lengths[scan[mwps_pkg::RIDX_W-1:0]]};
  assign overlap = (span_lo < rng_hi) && (rng_lo < span_hi);

  // Command handling, range scan and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      used      <= '0;
      scan      <= '0;
      excl      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            case (q_data.cmd)
              mwps_pkg::CMD_CLEAR: begin
                used <= '0;
              end
              mwps_pkg::CMD_LOAD: begin
                if (table_wr) begin
                  used <= used + 1'b1;
                end
              end
              mwps_pkg::CMD_HIT: begin
                scan  <= '0;
                excl  <= 1'b0;
                state <= B_SCAN;
              end
              default: begin
                state <= B_IDLE;
              end
            endcase
          end
        end
        B_SCAN: begin
          if (scan == used) begin
            state <= B_WAIT;
          end else begin
            excl <= excl | overlap;
            scan <= scan + 1'b1;
          end
        end
        B_WAIT: begin
          if (out_load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Range table writes, the current hit and the result register.
  always_ff @(posedge clk) begin
    if (table_wr) begin
      starts[used[mwps_pkg::RIDX_W-1:0]]  <= q_data.offset;
      lengths[used[mwps_pkg::RIDX_W-1:0]] <= q_data.capacity;
    end
    if (q_pop && (q_data.cmd == mwps_pkg::CMD_HIT)) begin
      cur <= q_data;
    end
    if (out_load) begin
      result.hit_kind        <= cur.kind;
      result.hit_offset      <= cur.offset;
      result.element_count   <= cur.count;
      result.array_pointer   <= cur.pointer;
      result.array_capacity  <= cur.capacity;
      result.inside_excluded <= excl;
      result.last_of_run     <= cur.last;
    end
  end

  `MWPS_ASSERT_ALWAYS(a_used_bound, clk, rst,
    used <= mwps_pkg::USED_W'(mwps_pkg::MAX_EXCLUDED_RANGES))
  `MWPS_ASSERT_IMPL(a_scan_bound, clk, rst, state == B_SCAN, scan <= used)
  `MWPS_ASSERT_NEXT(a_result_after_load, clk, rst, out_load, out_valid)

endmodule

@@ design/memory_word_pattern_scanner_core.sv @@
// Top level of the memory word pattern scanner: configuration registers and the two halves.
//
// Usage: items enter through a queue-style port (push/full) and results leave
// through one (empty/pop). An item is a scan start, an excluded range load or
// one 32-bit image word. Each image word can give an inline needle hit and an
// array header hit, in that order; last_of_run marks the final hit of a word.
// The user must write needle length and needle words over the APB port only
// while idle; the block itself does not enforce this. In the front end, an
// item is accepted and then classified; a word with hits holds the front end
// while each hit goes to the queue, and longer while the queue is full. Each
// hit then passes the back end's idle, scan and wait states; the scan reads the
// R stored excluded ranges (0 to 16) from the range table one entry per cycle.
// A two-entry queue lets the front end run ahead of the range check, and the
// output register lets the back end finish the next hit while a result waits.
// When the receiver stalls, the queue fills and full rises until pop is seen.
// Reset sets the needle length to 1, clears the needle words, the scan
// position, the range table and all pending work; no result is pending after.
module memory_word_pattern_scanner_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mwps_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output mwps_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [mwps_pkg::NLEN_W-1:0] needle_length;
  logic [63:0]                 needle_a;
  logic [63:0]                 needle_b;
  logic [63:0]                 needle_c;
  logic [63:0]                 needle_d;
  mwps_pkg::needle_t           needle;
  logic                        cfg_wr;
  logic [2:0]                  reg_idx;
  logic                        q_push;
  mwps_pkg::entry_t            q_wr_data;
  logic                        q_full;
  logic                        q_pop;
  mwps_pkg::entry_t            q_rd_data;
  logic                        q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign needle  = {needle_d, needle_c, needle_b, needle_a};

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length <= mwps_pkg::NLEN_W'(1);
      needle_a      <= '0;
      needle_b      <= '0;
      needle_c      <= '0;
      needle_d      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mwps_pkg::REG_NEEDLE_LENGTH: needle_length <= pwdata[mwps_pkg::NLEN_W-1:0];
        mwps_pkg::REG_NEEDLE_A:      needle_a      <= pwdata;
        mwps_pkg::REG_NEEDLE_B:      needle_b      <= pwdata;
        mwps_pkg::REG_NEEDLE_C:      needle_c      <= pwdata;
        mwps_pkg::REG_NEEDLE_D:      needle_d      <= pwdata;
        default: begin
          needle_length <= needle_length;
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      mwps_pkg::REG_NEEDLE_LENGTH: prdata = {{(64-mwps_pkg::NLEN_W){1'b0}}, needle_length};
      mwps_pkg::REG_NEEDLE_A:      prdata = needle_a;
      mwps_pkg::REG_NEEDLE_B:      prdata = needle_b;
      mwps_pkg::REG_NEEDLE_C:      prdata = needle_c;
      mwps_pkg::REG_NEEDLE_D:      prdata = needle_d;
      default:                     prdata = '0;
    endcase
  end

  mwps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .needle_length (needle_length),
    .needle        (needle),
    .q_push        (q_push),
    .q_data        (q_wr_data),
    .q_full        (q_full)
  );

  mwps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .wr_full  (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_rd_data),
    .rd_empty (q_empty)
  );

  mwps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_pop   (q_pop),
    .q_data  (q_rd_data),
    .q_empty (q_empty),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
